// ===== src/ngg_pkg.sv =====
// ----------------------------------------------------------------------------
// ngg_pkg
// Shared types, constants and the exponent table used by the noise gate
// gain computer.
// ----------------------------------------------------------------------------
package ngg_pkg;

  localparam int CHANNELS_DEFAULT = 2;

  localparam logic signed [15:0] DB_FLOOR   = -16'sd30720;
  localparam logic signed [15:0] GAIN_FLOOR = -16'sd32768;
  localparam logic [32:0] DB_PER_OCT_Q16 = 33'd394566;
  localparam logic [32:0] OCT_PER_DB_Q16 = 33'd2786635;

  // Register indexes on the configuration channel.
  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_RATIO       = 3'd1;
  localparam logic [2:0] REG_ATTACK      = 3'd2;
  localparam logic [2:0] REG_DECAY       = 3'd3;
  localparam logic [2:0] REG_INPUT_GAIN  = 3'd4;
  localparam logic [2:0] REG_OUTPUT_GAIN = 3'd5;

  typedef logic [30:0] exp_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry k holds 2^(2^-(k+1)) in Q1.30, built by truncating square roots.
  function automatic exp_tab_t make_exp_tab();
    exp_tab_t    t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int k = 0; k < 16; k++) begin
      t[k] = r[30:0];
      r = isqrt64(r << 30);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = make_exp_tab();

endpackage

// ===== src/noise_gate_gain_computer.sv =====
// ----------------------------------------------------------------------------
// noise_gate_gain_computer
// Downward expander gain computer: level to dB, envelope, gate gain, and
// scaling of each channel sample by the resulting linear factor.
// ----------------------------------------------------------------------------
// Usage: one transaction on the s_ side carries one audio frame: the
// detector RMS level and the left and right samples. One transaction on
// the m_ side returns the two scaled samples and the gate gain in dB.
// The block handles one frame at a time. All arithmetic runs through a
// single shared 33 x 33 bit signed multiplier with a registered product,
// so each multiply has an issue state and a use state. A frame passes
// through the log2 squaring, the dB conversion, the envelope, the gain,
// the exponent, the mantissa build and the scaling of each channel, in
// that order, and a new frame is accepted only once the last one has
// reached the output register. A zero level skips the log2 and dB steps.
// The log2 and mantissa loops each run sixteen iterations and handle one
// fraction bit per iteration, top bit first. s_tready is high only
// while the sequencer is idle. The finished result sits in an output
// register; if the receiver stalls, the next frame is still accepted and
// runs until it needs that register. Configuration writes are always
// accepted (cfg_ready is tied high) and should only be done while no frame
// is in flight. Reset (rst, synchronous) loads the default register values,
// clears the envelope to 0 dB and empties the output register.
// ----------------------------------------------------------------------------
module noise_gate_gain_computer #(
  parameter int CHANNELS = ngg_pkg::CHANNELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // detector_level, sample_left, sample_right
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_left, out_right, gain_db
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_MUL, S_SQ_ACC, S_DB_MUL, S_DB_ACC, S_ENV_MUL, S_ENV_ACC,
    S_GAIN_MUL, S_GAIN_ACC, S_EXP_MUL, S_EXP_ACC, S_MAN_MUL, S_MAN_ACC,
    S_SC_MUL, S_SC_ACC, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [15:0] threshold_db;
  logic [11:0]        ratio;
  logic [15:0]        attack_coef;
  logic [15:0]        decay_coef;
  logic signed [14:0] input_gain_db;
  logic signed [14:0] output_gain_db;

  // Working registers.
  logic signed [15:0] envelope_db;
  logic signed [15:0] smp [2];
  logic [3:0]         p;
  logic [30:0]        y;
  logic [15:0]        frac;
  logic [3:0]         cnt;
  logic signed [15:0] rms;
  logic signed [15:0] gain;
  logic signed [7:0]  n;
  logic [15:0]        f;
  logic [30:0]        m;
  logic               ch;
  logic signed [15:0] res [2];
  logic signed [65:0] prod;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  // Leading one of the level and its normalized mantissa.
  logic [3:0]  p_in;
  logic [15:0] lvl_in;
  always_comb begin
    lvl_in = s_tdata[15:0];
    p_in   = '0;
    for (int i = 0; i < 16; i++) begin
      if (lvl_in[i]) p_in = 4'(i);
    end
  end

  logic [15:0] lvl_norm;
  assign lvl_norm = lvl_in << (4'd15 - p_in);

  logic [31:0] y_sq;
  assign y_sq = prod[61:30];

  logic [20:0] neg_l2;
  assign neg_l2 = {(5'd16 - {1'b0, p}), 16'd0} - {5'd0, frac};

  logic signed [16:0] db_val;
  logic signed [16:0] rms_sum;
  assign db_val  = -17'(($unsigned(prod) + 66'd8388608) >> 24);
  assign rms_sum = db_val + 17'(input_gain_db);

  logic signed [16:0] env_diff;
  logic [15:0]        coef;
  assign env_diff = 17'(envelope_db) - 17'(rms);
  assign coef     = (rms > threshold_db) ? attack_coef : decay_coef;

  logic signed [65:0] env_rnd;
  assign env_rnd = (prod + 66'sd32768) >>> 16;

  logic [11:0]        slope;
  logic signed [16:0] thr_diff;
  logic signed [65:0] gain_rnd;
  assign slope    = (ratio > 12'd256) ? ratio - 12'd256 : 12'd0;
  assign thr_diff = 17'(envelope_db) - 17'(threshold_db);
  assign gain_rnd = (prod + 66'sd128) >>> 8;

  logic signed [17:0] d_sum;
  logic signed [65:0] t_val;
  assign d_sum = 18'(gain) + 18'(input_gain_db) + 18'(output_gain_db);
  assign t_val = (prod + 66'sd32768) >>> 16;

  // Sample scaling: round half up at a shift of 30 - n, capped at 48.
  logic signed [8:0]  sh_raw;
  logic [5:0]         sh;
  logic signed [63:0] sc_sum;
  logic signed [63:0] sc_v;
  logic signed [15:0] sc_sat;
  always_comb begin
    sh_raw = 9'sd30 - 9'(n);
    sh     = (sh_raw > 9'sd48) ? 6'd48 : sh_raw[5:0];
    sc_sum = 64'(prod) + (64'sd1 <<< (sh - 6'd1));
    sc_v   = sc_sum >>> sh;
    if (sc_v > 64'sd32767) sc_sat = 16'sd32767;
    else if (sc_v < -64'sd32768) sc_sat = -16'sd32768;
    else sc_sat = sc_v[15:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ_MUL: begin
        mul_a = {2'b0, y};
        mul_b = {2'b0, y};
      end
      S_DB_MUL: begin
        mul_a = {12'b0, neg_l2};
        mul_b = ngg_pkg::DB_PER_OCT_Q16;
      end
      S_ENV_MUL: begin
        mul_a = {17'b0, coef};
        mul_b = 33'(env_diff);
      end
      S_GAIN_MUL: begin
        mul_a = {21'b0, slope};
        mul_b = 33'(thr_diff);
      end
      S_EXP_MUL: begin
        mul_a = 33'(d_sum);
        mul_b = ngg_pkg::OCT_PER_DB_Q16;
      end
      S_MAN_MUL: begin
        mul_a = {2'b0, m};
        mul_b = {2'b0, ngg_pkg::EXP_TAB[cnt]};
      end
      S_SC_MUL: begin
        mul_a = 33'(smp[ch]);
        mul_b = {2'b0, m};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db   <= -16'sd4608;
      ratio          <= 12'd2560;
      attack_coef    <= 16'd65263;
      decay_coef     <= 16'd65522;
      input_gain_db  <= '0;
      output_gain_db <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ngg_pkg::REG_THRESHOLD:   threshold_db   <= cfg_data;
        ngg_pkg::REG_RATIO:       ratio          <= cfg_data[11:0];
        ngg_pkg::REG_ATTACK:      attack_coef    <= cfg_data;
        ngg_pkg::REG_DECAY:       decay_coef     <= cfg_data;
        ngg_pkg::REG_INPUT_GAIN:  input_gain_db  <= cfg_data[14:0];
        ngg_pkg::REG_OUTPUT_GAIN: output_gain_db <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      envelope_db <= '0;
      m_tvalid    <= 1'b0;
      cnt         <= '0;
      ch          <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded whenever it drains.
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            smp[0] <= s_tdata[31:16];
            smp[1] <= s_tdata[47:32];
            p      <= p_in;
            y      <= {lvl_norm, 15'd0};
            frac   <= '0;
            cnt    <= '0;
            if (lvl_in == 16'd0) begin
              rms   <= ngg_pkg::DB_FLOOR;
              state <= S_ENV_MUL;
            end else begin
              state <= S_SQ_MUL;
            end
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (y_sq[31]) begin
            y <= y_sq[31:1];
            frac[4'd15 - cnt] <= 1'b1;
          end else begin
            y <= y_sq[30:0];
          end
          cnt <= cnt + 4'd1;
          state <= (cnt == 4'd15) ? S_DB_MUL : S_SQ_MUL;
        end
        S_DB_MUL: state <= S_DB_ACC;
        S_DB_ACC: begin
          rms   <= (rms_sum < 17'(ngg_pkg::DB_FLOOR)) ? ngg_pkg::DB_FLOOR
                                                      : rms_sum[15:0];
          state <= S_ENV_MUL;
        end
        S_ENV_MUL: state <= S_ENV_ACC;
        S_ENV_ACC: begin
          envelope_db <= rms + env_rnd[15:0];
          state       <= S_GAIN_MUL;
        end
        S_GAIN_MUL: state <= S_GAIN_ACC;
        S_GAIN_ACC: begin
          if (envelope_db > threshold_db) gain <= '0;
          else if (gain_rnd < 66'(ngg_pkg::GAIN_FLOOR)) gain <= ngg_pkg::GAIN_FLOOR;
          else gain <= gain_rnd[15:0];
          state <= S_EXP_MUL;
        end
        S_EXP_MUL: state <= S_EXP_ACC;
        S_EXP_ACC: begin
          n     <= t_val[23:16];
          f     <= t_val[15:0];
          m     <= 31'd1 << 30;
          cnt   <= '0;
          state <= S_MAN_MUL;
        end
        S_MAN_MUL: state <= S_MAN_ACC;
        S_MAN_ACC: begin
          if (f[4'd15 - cnt]) m <= prod[60:30];
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            ch    <= 1'b0;
            state <= S_SC_MUL;
          end else begin
            state <= S_MAN_MUL;
          end
        end
        S_SC_MUL: state <= S_SC_ACC;
        S_SC_ACC: begin
          res[ch] <= (32'(ch) < CHANNELS) ? sc_sat : 16'sd0;
          if (ch) begin
            state <= S_OUT;
          end else begin
            ch    <= 1'b1;
            state <= S_SC_MUL;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {gain, res[1], res[0]};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_noise_gate_gain_computer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_noise_gate_gain_computer
// Self-checking bench for the noise gate gain computer. A scoreboard class
// keeps its own model of the gate (dB conversion, envelope, gain, linear
// scaling) and predicts every output frame from the accepted input frames.
// Stimulus runs through several register settings with random idling on
// both stream sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_noise_gate_gain_computer;

  // Indexes with no register behind them; writes to them must change nothing.
  localparam logic [2:0] REG_UNUSED      = 3'd6;
  localparam logic [2:0] REG_UNUSED_LAST = 3'd7;
  localparam int CHANNELS = 2;
  localparam longint CYCLE_LIMIT = 1000000;

  // Gate model with its own register copies and envelope state.
  class gate_scoreboard;
    logic signed [15:0] thr;
    logic [11:0]        ratio;
    logic [15:0]        atk;
    logic [15:0]        dcy;
    logic signed [14:0] gin;
    logic signed [14:0] gout;
    logic signed [15:0] envelope;
    logic [47:0]        pending_frames[$];
    int                 errors;

    function void reset_state();
      thr = -16'sd4608;
      ratio = 12'd2560;
      atk = 16'd65263;
      dcy = 16'd65522;
      gin = '0;
      gout = '0;
      envelope = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        ngg_pkg::REG_THRESHOLD:   thr = val;
        ngg_pkg::REG_RATIO:       ratio = val[11:0];
        ngg_pkg::REG_ATTACK:      atk = val;
        ngg_pkg::REG_DECAY:       dcy = val;
        ngg_pkg::REG_INPUT_GAIN:  gin = val[14:0];
        ngg_pkg::REG_OUTPUT_GAIN: gout = val[14:0];
        default: ;
      endcase
    endfunction

    // Floor of the square root, found bit by bit from the top.
    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Level in dB: 6.0206 times log2 of the Q0.16 level, log2 by squaring.
    function int level_db(logic [15:0] lvl);
      int              p;
      longint unsigned y;
      logic [15:0]     frac;
      longint          octs;
      p = 15;
      frac = '0;
      while (p > 0 && !lvl[p]) p--;
      y = (64'(lvl) << (15 - p)) << 15;
      for (int i = 1; i <= 16; i++) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          frac[16 - i] = 1'b1;
        end
      end
      octs = -(longint'(p - 16) * 65536 + longint'(frac));
      return -int'((octs * 394566 + (64'sd1 << 23)) >>> 24);
    endfunction

    // 2^(f/65536) as Q1.30 from a table of truncated square roots.
    function longint unsigned exp2_q30(logic [15:0] f);
      longint unsigned mant;
      longint unsigned root;
      mant = 64'd1 << 30;
      root = sqrt_floor(64'd1 << 61);
      for (int k = 1; k <= 16; k++) begin
        if (f[16 - k]) mant = (mant * root) >> 30;
        root = sqrt_floor(root << 30);
      end
      return mant;
    endfunction

    function logic [15:0] scaled(logic signed [15:0] s, longint mant, longint n);
      longint prod;
      longint sh;
      longint v;
      prod = longint'(s) * mant;
      sh = 30 - n;
      if (sh > 48) sh = 48;
      v = (prod + (64'sd1 <<< (sh - 1))) >>> sh;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    // Called for each accepted input transaction.
    function void note_frame(logic [47:0] frame);
      logic [15:0] lvl;
      int          rms;
      int          coef;
      int          slope;
      longint      g;
      longint      d;
      longint      t;
      longint      n;
      longint      mant;
      logic [15:0] outs[2];
      lvl = frame[15:0];
      rms = (lvl == 0) ? -30720 : level_db(lvl) + int'(gin);
      if (rms < -30720) rms = -30720;
      coef = (rms > int'(thr)) ? int'(atk) : int'(dcy);
      g = (longint'(coef) * longint'(int'(envelope) - rms) + 32768) >>> 16;
      envelope = 16'(rms + int'(g));
      slope = (ratio > 256) ? int'(ratio) - 256 : 0;
      if (envelope > thr) begin
        g = 0;
      end else begin
        g = (longint'(slope) * longint'(int'(envelope) - int'(thr)) + 128) >>> 8;
        if (g < -32768) g = -32768;
      end
      d = g + longint'(gin) + longint'(gout);
      t = (d * 2786635 + 32768) >>> 16;
      n = t >>> 16;
      mant = longint'(exp2_q30(16'(t - n * 65536)));
      for (int c = 0; c < 2; c++)
        outs[c] = (c < CHANNELS) ? scaled(frame[16 + 16 * c +: 16], mant, n) : '0;
      pending_frames.push_back({g[15:0], outs[1], outs[0]});
    endfunction

    // Called for each accepted output transaction.
    function void check_result(logic [47:0] got);
      logic [47:0] want;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected output transaction %h", $time, got);
        errors++;
        return;
      end
      want = pending_frames.pop_front();
      if (got[15:0] !== want[15:0]) begin
        $display("%0t: out_left expected %0d, got %0d", $time,
                 $signed(want[15:0]), $signed(got[15:0]));
        errors++;
      end
      if (got[31:16] !== want[31:16]) begin
        $display("%0t: out_right expected %0d, got %0d", $time,
                 $signed(want[31:16]), $signed(got[31:16]));
        errors++;
      end
      if (got[47:32] !== want[47:32]) begin
        $display("%0t: gain_db expected %0d, got %0d", $time,
                 $signed(want[47:32]), $signed(got[47:32]));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // detector_level, sample_left, sample_right
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // out_left, out_right, gain_db
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  gate_scoreboard gate_sb;
  longint         cycles;
  int             results_seen;
  bit             long_hold_done;

  noise_gate_gain_computer #(.CHANNELS(CHANNELS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Both monitors sample at the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) gate_sb.note_frame(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      gate_sb.check_result(m_tdata);
      results_seen++;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, and once a long hold-off so the block backs up
  // and stops taking frames while the sender keeps offering them.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        stall = 600;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    gate_sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Offers one frame after a random gap and returns once it is accepted.
  task automatic send_frame(logic [15:0] lvl, logic [15:0] left, logic [15:0] right);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {right, left, lvl};
    do @(posedge clk); while (!s_tready);
  endtask

  // Every outstanding frame answered, then a margin above the block latency.
  // The first edge lets the monitor note the frame accepted last.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (gate_sb.pending_frames.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Levels spread over the whole dB range, so both sides of the threshold
  // are visited often.
  task automatic random_frames(int count);
    for (int i = 0; i < count; i++)
      send_frame(16'($urandom_range(0, 65535) >> $urandom_range(0, 16)),
                 16'($urandom), 16'($urandom));
  endtask

  task automatic load_regs(int thr_v, int ratio_v, int atk_v, int dcy_v,
                           int gin_v, int gout_v);
    write_cfg(ngg_pkg::REG_THRESHOLD, 16'(thr_v));
    write_cfg(ngg_pkg::REG_RATIO, 16'(ratio_v));
    write_cfg(ngg_pkg::REG_ATTACK, 16'(atk_v));
    write_cfg(ngg_pkg::REG_DECAY, 16'(dcy_v));
    write_cfg(ngg_pkg::REG_INPUT_GAIN, 16'(gin_v));
    write_cfg(ngg_pkg::REG_OUTPUT_GAIN, 16'(gout_v));
  endtask

  initial begin
    gate_sb = new();
    gate_sb.reset_state();
    cycles = 0;
    results_seen = 0;
    long_hold_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames at the reset settings: zero level, smallest and largest
    // level, mid levels and sample extremes.
    send_frame(16'd0, 16'h7FFF, 16'h8000);
    send_frame(16'd1, 16'h8000, 16'h7FFF);
    send_frame(16'hFFFF, 16'h7FFF, 16'h8000);
    send_frame(16'hFFFF, 16'hFFFF, 16'h0001);
    send_frame(16'h0100, 16'h0000, 16'h5555);
    send_frame(16'h8000, 16'hAAAA, 16'h5555);

    // Hot gains with the loudest level push the scaled samples into
    // saturation; fast envelope and a steep slope reach the gain floor.
    drain();
    load_regs(3072, 2560, 0, 0, 3072, 3072);
    send_frame(16'hFFFF, 16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'h7FFF, 16'h8000);
    send_frame(16'h0001, 16'h4000, 16'hC000);
    send_frame(16'h0000, 16'h7FFF, 16'h8000);
    // A ratio under one means no expansion, whatever the level.
    drain();
    write_cfg(ngg_pkg::REG_RATIO, 16'd100);
    write_cfg(REG_UNUSED, 16'hFFFF);
    write_cfg(REG_UNUSED_LAST, 16'h1234);
    send_frame(16'h0000, 16'h7FFF, 16'h8000);
    send_frame(16'h0003, 16'h1234, 16'hEDCB);
    // Deepest input and output gains with the lowest threshold.
    drain();
    load_regs(-30720, 256, 65535, 65535, -12288, -12288);
    send_frame(16'hFFFF, 16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'h7FFF, 16'h8000);
    send_frame(16'h0010, 16'h7FFF, 16'h8000);

    // Random part: reset settings first, then extremes and random settings.
    drain();
    load_regs(-4608, 2560, 65263, 65522, 0, 0);
    random_frames(300);
    drain();
    load_regs(3072, 2560, 0, 65535, 3072, -12288);
    random_frames(200);
    drain();
    load_regs(-30720, 256, 65535, 0, -12288, 3072);
    random_frames(200);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      load_regs($urandom_range(0, 33792) - 30720, $urandom_range(0, 4095),
                $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 15360) - 12288, $urandom_range(0, 15360) - 12288);
      random_frames(200);
    end

    drain();
    if (gate_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
